// ===== design/stable_priority_ready_queue_unit_macros.svh =====
// Assertion macros shared by the ready queue RTL.
`ifndef STABLE_PRIORITY_READY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_READY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// Types and constants of the stable priority ready queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_REMOVE  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [ID_W-1:0]   item_pid;
    logic [PRIO_W-1:0] item_priority;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              taken_valid;
    logic [ID_W-1:0]   taken_pid;
    logic [PRIO_W-1:0] taken_priority;
    logic              head_valid;
    logic [ID_W-1:0]   head_pid;
    logic [PRIO_W-1:0] head_priority;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   pid;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell.
  typedef struct packed {
    action_t action;
    entry_t  item;
    logic    wr;
  } cmd_t;

  // Handed from a cell to its neighbor toward the tail.
  typedef struct packed {
    entry_t ent;
    logic   gt;
    logic   found;
    entry_t taken;
  } fwd_t;

endpackage

// ===== design/spq_cell.sv =====
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
module spq_cell (
  input  logic            clk,
  input  spq_pkg::cmd_t   cmd,
  input  logic            occ,
  input  logic            is_head,
  input  spq_pkg::fwd_t   fwd_in,
  input  spq_pkg::entry_t back_in,
  output spq_pkg::fwd_t   fwd_out,
  output spq_pkg::entry_t back_out,
  output spq_pkg::entry_t ent_next
);
  import spq_pkg::*;

  entry_t ent;
  logic   gt;
  logic   match;

  assign gt    = occ && (ent.prio > cmd.item.prio);
  assign match = occ && ((cmd.action == ACT_DEQUEUE) ? is_head
                                                     : (ent.pid == cmd.item.pid));

  always_comb begin
    fwd_out.ent   = ent;
    fwd_out.gt    = gt;
    fwd_out.found = fwd_in.found || match;
    fwd_out.taken = (match && !fwd_in.found) ? ent : fwd_in.taken;
  end

  assign back_out = ent;

  always_comb begin
    ent_next = ent;
    unique case (cmd.action)
      ACT_ENQUEUE: begin
        // upstream cell moves right, or the new entry lands here
        if (fwd_in.gt) begin
          ent_next = fwd_in.ent;
        end else if (gt || !occ) begin
          ent_next = cmd.item;
        end
      end
      ACT_DEQUEUE, ACT_REMOVE: begin
        // at and past the removed slot, pull from the right
        if (fwd_out.found) begin
          ent_next = back_in;
        end
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      ent <= ent_next;
    end
  end

endmodule

// ===== design/stable_priority_ready_queue_unit.sv =====
// Top level of the stable priority ready queue: cell row, count and result register.
//
// Bounded queue of (pid, priority) entries kept sorted by ascending priority,
// ties in arrival order. Each request transfer carries one action (enqueue,
// dequeue head, remove first entry with a given pid) and produces exactly one
// response transfer with status, the taken entry, the head after the action
// and the entry count. Rate: one request per cycle, response registered;
// every cell compares against the broadcast request at once and the whole row
// shifts in the same clock edge. The only wait is the response register: a new
// request is taken while the previous response is either absent or being
// taken in that cycle. Enqueue into a full queue (CAPACITY entries) is dropped
// with status full; dequeue on an empty queue reports empty; a remove with no
// matching pid reports not-found; action code 3 is a no-op with status ok.
// Slot contents are not cleared by reset; only the entry count and rsp_valid are.
module stable_priority_ready_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req_item,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp_item
);
  import spq_pkg::*;

  `include "stable_priority_ready_queue_unit_macros.svh"

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  logic             found;
  cmd_t             cmd;
  rsp_t             rsp_next;
  entry_t           head_next;
  entry_t           head_out;
  entry_t           taken;
  status_t          status;
  logic             taken_valid;
  logic             drop_enq;
  logic             deq_hit;
  logic             rsp_cnt_ok;

  fwd_t   fwd  [CAPACITY+1];
  entry_t back [CAPACITY+1];

  // the output register frees up when it is empty or being drained
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  assign fwd[0]         = '0;
  assign back[CAPACITY] = '0;

  assign found = fwd[CAPACITY].found;
  assign taken = fwd[CAPACITY].taken;

  always_comb begin
    cmd.action = req_item.action;
    cmd.item   = '{pid: req_item.item_pid, prio: req_item.item_priority};
    // a full enqueue must leave the row untouched
    cmd.wr     = accept && !((req_item.action == ACT_ENQUEUE) && full);
  end

  // a dropped enqueue leaves the current head in place
  assign head_out = cmd.wr ? head_next : back[0];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
      if (gi == 0) begin : g_head
        spq_cell u_cell (
          .clk      (clk),
          .cmd      (cmd),
          .occ      (IDX < count),
          .is_head  (1'b1),
          .fwd_in   (fwd[gi]),
          .back_in  (back[gi+1]),
          .fwd_out  (fwd[gi+1]),
          .back_out (back[gi]),
          .ent_next (head_next)
        );
      end else begin : g_body
        spq_cell u_cell (
          .clk      (clk),
          .cmd      (cmd),
          .occ      (IDX < count),
          .is_head  (1'b0),
          .fwd_in   (fwd[gi]),
          .back_in  (back[gi+1]),
          .fwd_out  (fwd[gi+1]),
          .back_out (back[gi]),
          .ent_next ()
        );
      end
    end
  endgenerate

  // status and count update per action
  always_comb begin
    status      = ST_OK;
    taken_valid = 1'b0;
    count_next  = count;
    unique case (req_item.action)
      ACT_ENQUEUE: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      ACT_DEQUEUE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          taken_valid = 1'b1;
          count_next  = count - CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (!found) begin
          status = ST_NOTFOUND;
        end else begin
          taken_valid = 1'b1;
          count_next  = count - CNT_W'(1);
        end
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    rsp_next.status         = status;
    rsp_next.taken_valid    = taken_valid;
    rsp_next.taken_pid      = taken_valid ? taken.pid  : '0;
    rsp_next.taken_priority = taken_valid ? taken.prio : '0;
    rsp_next.head_valid     = (count_next != '0);
    rsp_next.head_pid       = (count_next != '0) ? head_out.pid  : '0;
    rsp_next.head_priority  = (count_next != '0) ? head_out.prio : '0;
    rsp_next.entry_count    = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_item <= rsp_next;
    end
  end

  assign drop_enq   = accept && (req_item.action == ACT_ENQUEUE) && full;
  assign deq_hit    = accept && (req_item.action == ACT_DEQUEUE) && !empty;
  assign rsp_cnt_ok = (rsp_item.entry_count == COUNT_W'(count));

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "count over capacity")
  `SPQ_ASSERT_NEXT(a_full_drop, drop_enq, count == $past(count), "full enqueue changed count")
  `SPQ_ASSERT_NEXT(a_deq_count, deq_hit, count == $past(count) - CNT_W'(1), "dequeue kept count")
  `SPQ_ASSERT_NEXT(a_rsp_match, accept, rsp_valid && rsp_cnt_ok, "response count mismatch")

endmodule
